// ===== sv/bfm_pkg.sv =====
`default_nettype none

package bfm_pkg;

	// event buffer slots, one per place in the fixed check order
	localparam int NSLOT = 9;

	// operations
	localparam logic [1:0] OP_TICK   = 2'd0;
	localparam logic [1:0] OP_INJECT = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	// register indexes
	localparam logic [2:0] REG_TEMP_CRITICAL  = 3'd0;
	localparam logic [2:0] REG_TEMP_WARNING   = 3'd1;
	localparam logic [2:0] REG_TEMP_LOW       = 3'd2;
	localparam logic [2:0] REG_TEMP_VALID_MIN = 3'd3;
	localparam logic [2:0] REG_TEMP_VALID_MAX = 3'd4;
	localparam logic [2:0] REG_VOLT_VALID_MIN = 3'd5;
	localparam logic [2:0] REG_VOLT_VALID_MAX = 3'd6;
	localparam logic [2:0] REG_SOC_LOW        = 3'd7;

	// register reset values
	localparam logic signed [11:0] TEMP_CRITICAL_RST  = 12'sd750;
	localparam logic signed [11:0] TEMP_WARNING_RST   = 12'sd600;
	localparam logic signed [11:0] TEMP_LOW_RST       = 12'sd50;
	localparam logic signed [11:0] TEMP_VALID_MIN_RST = -12'sd400;
	localparam logic signed [11:0] TEMP_VALID_MAX_RST = 12'sd1000;
	localparam logic [13:0]        VOLT_VALID_MIN_RST = 14'd2000;
	localparam logic [13:0]        VOLT_VALID_MAX_RST = 14'd5000;
	localparam logic [9:0]         SOC_LOW_RST        = 10'd150;

	// fixed charge limits in per mille
	localparam logic signed [11:0] SOC_CRIT_PM = 12'sd50;
	localparam logic signed [11:0] SOC_MAX_PM  = 12'sd1000;

	// trouble codes
	localparam logic [3:0] DTC_OVERTEMP_WARN = 4'd1;
	localparam logic [3:0] DTC_OVERTEMP_CRIT = 4'd2;
	localparam logic [3:0] DTC_UNDERTEMP     = 4'd3;
	localparam logic [3:0] DTC_SENSOR_RANGE  = 4'd4;
	localparam logic [3:0] DTC_INJECTED      = 4'd5;
	localparam logic [3:0] DTC_SOC_LOW       = 4'd6;
	localparam logic [3:0] DTC_SOC_CRIT      = 4'd7;
	localparam logic [3:0] DTC_SHUTDOWN      = 4'd8;

	// event kinds and severities
	localparam logic KIND_RAISED   = 1'b0;
	localparam logic KIND_RESOLVED = 1'b1;
	localparam logic [1:0] SEV_INFO = 2'd0;
	localparam logic [1:0] SEV_WARN = 2'd1;
	localparam logic [1:0] SEV_CRIT = 2'd2;

	typedef struct packed {
		logic [1:0]         op;
		logic [31:0]        stamp_ms;
		logic signed [11:0] temperature_dc;
		logic [13:0]        voltage_dv;
		logic signed [11:0] soc_permille;
		logic               shutdown;
		logic [15:0]        inject_ticks;
	} in_t;

	typedef struct packed {
		logic [3:0]  dtc;
		logic        event_kind;
		logic [1:0]  severity;
		logic [31:0] event_time;
		logic        last;
	} out_t;

	typedef struct packed {
		logic [3:0]  code;
		logic        kind;
		logic [1:0]  sev;
		logic [31:0] t;
	} ev_t;

	typedef ev_t [NSLOT-1:0] ev_vec_t;

	typedef struct packed {
		logic signed [11:0] temp_critical;
		logic signed [11:0] temp_warning;
		logic signed [11:0] temp_low;
		logic signed [11:0] temp_valid_min;
		logic signed [11:0] temp_valid_max;
		logic [13:0]        volt_valid_min;
		logic [13:0]        volt_valid_max;
		logic [9:0]         soc_low;
	} cfg_t;

	typedef struct packed {
		logic [NSLOT-1:0] pend;
		logic             free;
	} emit_st_t;

endpackage

`default_nettype wire

// ===== sv/bfm_eval.sv =====
`default_nettype none

module bfm_eval (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         en,
	input  wire bfm_pkg::in_t                 item,
	input  wire bfm_pkg::cfg_t                cfg,
	output logic [bfm_pkg::NSLOT-1:0]         ev_valid,
	output bfm_pkg::ev_vec_t                  ev
);

	logic [7:0]  active_q;
	logic [15:0] inject_q;
	logic [31:0] raise_time_q [8];

	logic        is_tick;
	logic        inj_nz;
	logic [15:0] inj_dec;
	logic        inj_still;
	logic        r_shut, r_crit, r_warn, r_under, r_range;
	logic        soc_crit, soc_low;
	logic [7:0]  mask_tick;
	logic [7:0]  raise_wr;
	logic [31:0] t;

	function automatic bfm_pkg::ev_t mk(input logic [3:0] code, input logic kind,
			input logic [1:0] sev, input logic [31:0] tm);
		bfm_pkg::ev_t e;
		e.code = code;
		e.kind = kind;
		e.sev  = sev;
		e.t    = tm;
		return e;
	endfunction

	always_comb begin
		t         = item.stamp_ms;
		is_tick   = (item.op == bfm_pkg::OP_TICK);
		inj_nz    = (inject_q != 16'd0);
		inj_dec   = inject_q - 16'd1;
		inj_still = inj_nz && (inj_dec != 16'd0);

		r_shut  = item.shutdown;
		r_crit  = item.temperature_dc > cfg.temp_critical;
		r_warn  = (item.temperature_dc > cfg.temp_warning) && !r_crit;
		r_under = item.temperature_dc < cfg.temp_low;
		r_range = (item.temperature_dc < cfg.temp_valid_min) ||
			(item.temperature_dc > cfg.temp_valid_max) ||
			(item.voltage_dv < cfg.volt_valid_min) ||
			(item.voltage_dv > cfg.volt_valid_max) ||
			item.soc_permille[11] || (item.soc_permille > bfm_pkg::SOC_MAX_PM) ||
			inj_still;
		soc_crit = item.soc_permille < bfm_pkg::SOC_CRIT_PM;
		soc_low  = item.soc_permille < $signed({2'b00, cfg.soc_low});

		// injected code: raise, then resolve when the count runs out
		ev[0] = mk(bfm_pkg::DTC_INJECTED, bfm_pkg::KIND_RAISED, bfm_pkg::SEV_CRIT, t);
		ev_valid[0] = inj_nz && !active_q[4];
		ev[1] = mk(bfm_pkg::DTC_INJECTED, bfm_pkg::KIND_RESOLVED, bfm_pkg::SEV_INFO,
			active_q[4] ? raise_time_q[4] : t);
		ev_valid[1] = inj_nz && !inj_still;

		ev[2] = r_shut ? mk(bfm_pkg::DTC_SHUTDOWN, bfm_pkg::KIND_RAISED, bfm_pkg::SEV_CRIT, t)
			: mk(bfm_pkg::DTC_SHUTDOWN, bfm_pkg::KIND_RESOLVED, bfm_pkg::SEV_INFO,
			raise_time_q[7]);
		ev_valid[2] = r_shut ^ active_q[7];

		ev[3] = r_crit ? mk(bfm_pkg::DTC_OVERTEMP_CRIT, bfm_pkg::KIND_RAISED,
			bfm_pkg::SEV_CRIT, t)
			: mk(bfm_pkg::DTC_OVERTEMP_CRIT, bfm_pkg::KIND_RESOLVED, bfm_pkg::SEV_INFO,
			raise_time_q[1]);
		ev_valid[3] = r_crit ^ active_q[1];

		ev[4] = r_warn ? mk(bfm_pkg::DTC_OVERTEMP_WARN, bfm_pkg::KIND_RAISED,
			bfm_pkg::SEV_WARN, t)
			: mk(bfm_pkg::DTC_OVERTEMP_WARN, bfm_pkg::KIND_RESOLVED, bfm_pkg::SEV_INFO,
			raise_time_q[0]);
		ev_valid[4] = r_warn ^ active_q[0];

		ev[5] = r_under ? mk(bfm_pkg::DTC_UNDERTEMP, bfm_pkg::KIND_RAISED,
			bfm_pkg::SEV_WARN, t)
			: mk(bfm_pkg::DTC_UNDERTEMP, bfm_pkg::KIND_RESOLVED, bfm_pkg::SEV_INFO,
			raise_time_q[2]);
		ev_valid[5] = r_under ^ active_q[2];

		ev[6] = r_range ? mk(bfm_pkg::DTC_SENSOR_RANGE, bfm_pkg::KIND_RAISED,
			bfm_pkg::SEV_CRIT, t)
			: mk(bfm_pkg::DTC_SENSOR_RANGE, bfm_pkg::KIND_RESOLVED, bfm_pkg::SEV_INFO,
			raise_time_q[3]);
		ev_valid[6] = r_range ^ active_q[3];

		// charge: critical and low never clear each other on a raise
		if (soc_crit) begin
			ev[7] = mk(bfm_pkg::DTC_SOC_CRIT, bfm_pkg::KIND_RAISED, bfm_pkg::SEV_CRIT, t);
			ev_valid[7] = !active_q[6];
		end else if (soc_low) begin
			ev[7] = mk(bfm_pkg::DTC_SOC_LOW, bfm_pkg::KIND_RAISED, bfm_pkg::SEV_WARN, t);
			ev_valid[7] = !active_q[5];
		end else begin
			ev[7] = mk(bfm_pkg::DTC_SOC_LOW, bfm_pkg::KIND_RESOLVED, bfm_pkg::SEV_INFO,
				raise_time_q[5]);
			ev_valid[7] = active_q[5];
		end
		ev[8] = mk(bfm_pkg::DTC_SOC_CRIT, bfm_pkg::KIND_RESOLVED, bfm_pkg::SEV_INFO,
			raise_time_q[6]);
		ev_valid[8] = !soc_crit && !soc_low && active_q[6];

		if (!is_tick) begin
			ev_valid = '0;
		end

		mask_tick[0] = r_warn;
		mask_tick[1] = r_crit;
		mask_tick[2] = r_under;
		mask_tick[3] = r_range;
		mask_tick[4] = inj_nz ? inj_still : active_q[4];
		mask_tick[5] = soc_crit ? active_q[5] : soc_low;
		mask_tick[6] = soc_crit ? 1'b1 : (soc_low ? active_q[6] : 1'b0);
		mask_tick[7] = r_shut;

		raise_wr = is_tick ? (mask_tick & ~active_q) : 8'd0;
		if (is_tick && inj_nz && !active_q[4]) begin
			raise_wr[4] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			inject_q <= '0;
		end else if (en) begin
			case (item.op)
				bfm_pkg::OP_TICK: begin
					active_q <= mask_tick;
					if (inj_nz) begin
						inject_q <= inj_dec;
					end
				end
				bfm_pkg::OP_INJECT: begin
					inject_q <= item.inject_ticks;
				end
				bfm_pkg::OP_CLEAR: begin
					active_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 8; i++) begin
			if (en && raise_wr[i]) begin
				raise_time_q[i] <= t;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/bfm_emit.sv =====
`default_nettype none

module bfm_emit (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         push,
	input  wire logic [bfm_pkg::NSLOT-1:0]    push_valid,
	input  wire bfm_pkg::ev_vec_t             push_ev,
	output bfm_pkg::emit_st_t                 st,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output bfm_pkg::out_t                     out_data
);

	logic [bfm_pkg::NSLOT-1:0] pend_q;
	bfm_pkg::ev_vec_t          slot_q;
	logic                      out_valid_q;
	bfm_pkg::out_t             out_q;

	logic [bfm_pkg::NSLOT-1:0] pop_sel;
	logic [bfm_pkg::NSLOT-1:0] pend_after;
	logic                      load;
	bfm_pkg::ev_t              pick;

	always_comb begin
		// lowest pending slot goes first
		pop_sel    = pend_q & (~pend_q + {{(bfm_pkg::NSLOT-1){1'b0}}, 1'b1});
		load       = (pend_q != '0) && (!out_valid_q || out_ready);
		pend_after = load ? (pend_q & ~pop_sel) : pend_q;
		pick       = '0;
		for (int i = 0; i < bfm_pkg::NSLOT; i++) begin
			if (pop_sel[i]) begin
				pick = pick | slot_q[i];
			end
		end
		st.pend = pend_q;
		st.free = (pend_after == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			pend_q <= push ? push_valid : pend_after;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q <= push_ev;
		end
		if (load) begin
			out_q.dtc        <= pick.code;
			out_q.event_kind <= pick.kind;
			out_q.severity   <= pick.sev;
			out_q.event_time <= pick.t;
			out_q.last       <= ((pend_q & ~pop_sel) == '0);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

// ===== sv/battery_fault_monitor.sv =====
// battery fault monitor: threshold checks on battery samples with trouble-code events
//
// input channel (in_valid / in_ready / in_data): one beat per tick, fault-injection
// start or clear of active faults. output channel (out_valid / out_ready / out_data):
// one beat per raised or resolved trouble code, in fixed check order, with last set
// on the final beat of a tick. inject and clear beats, and ticks that change nothing,
// give no output beat.
// a tick in the input register is evaluated once the event buffer is free; its events
// pass through the buffer and the output register. one output beat per cycle while
// out_ready is high; a tick that raises or resolves k codes holds the event buffer
// until its k beats have left (at most nine), so ticks with at most one event can be
// taken every cycle. the buffer drain rate sets the pace. when the receiver stalls,
// the output register holds its beat, the event buffer fills, and in_ready falls once
// the input register holds a beat it cannot evaluate. reset clears the active-code
// mask, the injection counter, all valid flags and loads the threshold registers with
// their defaults; raise times need no reset. cfg_we writes register cfg_addr with
// cfg_wdata at once; the user must write only while the block is idle (not enforced).
`default_nettype none

module battery_fault_monitor (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire bfm_pkg::in_t  in_data,
	output logic               out_valid,
	input  wire logic          out_ready,
	output bfm_pkg::out_t      out_data,
	input  wire logic          cfg_we,
	input  wire logic [2:0]    cfg_addr,
	input  wire logic [13:0]   cfg_wdata
);

	// input register
	logic         valid_s1;
	bfm_pkg::in_t item_s1;

	// threshold registers
	bfm_pkg::cfg_t cfg_q;

	logic                      eval_en;
	logic [bfm_pkg::NSLOT-1:0] ev_valid;
	bfm_pkg::ev_vec_t          ev;
	bfm_pkg::emit_st_t         st;

	// evaluate once the event buffer empties, possibly in the cycle it drains
	assign eval_en  = valid_s1 && st.free;
	assign in_ready = !valid_s1 || st.free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (eval_en) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	// configuration writes, no read-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.temp_critical  <= bfm_pkg::TEMP_CRITICAL_RST;
			cfg_q.temp_warning   <= bfm_pkg::TEMP_WARNING_RST;
			cfg_q.temp_low       <= bfm_pkg::TEMP_LOW_RST;
			cfg_q.temp_valid_min <= bfm_pkg::TEMP_VALID_MIN_RST;
			cfg_q.temp_valid_max <= bfm_pkg::TEMP_VALID_MAX_RST;
			cfg_q.volt_valid_min <= bfm_pkg::VOLT_VALID_MIN_RST;
			cfg_q.volt_valid_max <= bfm_pkg::VOLT_VALID_MAX_RST;
			cfg_q.soc_low        <= bfm_pkg::SOC_LOW_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				bfm_pkg::REG_TEMP_CRITICAL:  cfg_q.temp_critical  <= $signed(cfg_wdata[11:0]);
				bfm_pkg::REG_TEMP_WARNING:   cfg_q.temp_warning   <= $signed(cfg_wdata[11:0]);
				bfm_pkg::REG_TEMP_LOW:       cfg_q.temp_low       <= $signed(cfg_wdata[11:0]);
				bfm_pkg::REG_TEMP_VALID_MIN: cfg_q.temp_valid_min <= $signed(cfg_wdata[11:0]);
				bfm_pkg::REG_TEMP_VALID_MAX: cfg_q.temp_valid_max <= $signed(cfg_wdata[11:0]);
				bfm_pkg::REG_VOLT_VALID_MIN: cfg_q.volt_valid_min <= cfg_wdata;
				bfm_pkg::REG_VOLT_VALID_MAX: cfg_q.volt_valid_max <= cfg_wdata;
				bfm_pkg::REG_SOC_LOW:        cfg_q.soc_low        <= cfg_wdata[9:0];
				default: begin
				end
			endcase
		end
	end

	// checks and fault state: one pass per beat
	bfm_eval u_eval (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (eval_en),
		.item     (item_s1),
		.cfg      (cfg_q),
		.ev_valid (ev_valid),
		.ev       (ev)
	);

	// event buffer and output register
	bfm_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (eval_en),
		.push_valid (ev_valid),
		.push_ev    (ev),
		.st         (st),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

	// whenever events are pending, out_valid is high on the next cycle
	a_pend_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(st.pend != '0) |=> out_valid)
		else $error("pending event did not reach output");

	// a new tick is only taken into the buffer once it is empty or draining its last
	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		eval_en |-> ((st.pend == '0) || $onehot(st.pend)))
		else $error("event buffer overwritten");

	// resolve beats carry info severity, raise beats never do
	a_sev: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((out_data.event_kind == bfm_pkg::KIND_RESOLVED) ==
		(out_data.severity == bfm_pkg::SEV_INFO)))
		else $error("severity does not match event kind");

	// only codes one to eight leave the block
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.dtc != 4'd0 && out_data.dtc[3:0] <= 4'd8))
		else $error("trouble code out of range");

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;

	// the op code left spare by the block: accepted and ignored
	localparam logic [1:0] OP_SPARE = 2'd3;

	// cycles to let pass once nothing is pending, so the last beats work through the pipeline
	localparam int SETTLE_CYCLES = 8;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// input channel, driven from the start so nothing floats before reset
	logic         in_valid = 1'b0;
	logic         in_ready;
	bfm_pkg::in_t in_data = '0;

	// output channel
	logic          out_valid;
	logic          out_ready = 1'b0;
	bfm_pkg::out_t out_data;

	// threshold register write port
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_addr = '0;
	logic [13:0] cfg_wdata = '0;

	// beats waiting for the driver, and trouble-code events still owed by the block
	bfm_pkg::in_t  sample_q[$];
	bfm_pkg::out_t dtc_event_q[$];

	// shadow of the block's state and threshold registers
	bfm_pkg::cfg_t limits;
	logic [7:0]    model_mask;
	logic [31:0]   model_raise_ms [1:8];
	logic [15:0]   model_inject_left;

	// idling control: chance per cycle of starting a burst, and none at all when calm
	int   send_pct = 0;
	int   recv_pct = 0;
	int   send_gap = 0;
	int   recv_gap = 0;
	logic calm = 1'b0;

	int            mismatches = 0;
	logic [31:0]   clock_ms;
	bfm_pkg::out_t want_ev;

	battery_fault_monitor dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int rnd(input int lo, input int hi);
		return lo + int'($urandom_range(0, hi - lo));
	endfunction

	// mostly hug a threshold so both sides of each compare get hit, else anywhere in range
	function automatic int near_mark(input int mark, input int lo, input int hi);
		int v;
		if ($urandom_range(0, 2) == 0)
			v = rnd(lo, hi);
		else
			v = mark + rnd(-3, 3);
		if (v < lo)
			v = lo;
		if (v > hi)
			v = hi;
		return v;
	endfunction

	// ---------------------------------------------------------------- prediction

	task automatic post_raise(input logic [3:0] code, input logic [1:0] sev,
			input logic [31:0] ts);
		bfm_pkg::out_t ev;
		// a code already active stays silent
		if (!model_mask[code - 4'd1]) begin
			model_mask[code - 4'd1] = 1'b1;
			model_raise_ms[code] = ts;
			ev.dtc = code;
			ev.event_kind = bfm_pkg::KIND_RAISED;
			ev.severity = sev;
			ev.event_time = ts;
			ev.last = 1'b0;
			dtc_event_q.insert(dtc_event_q.size(), ev);
		end
	endtask

	task automatic post_resolve(input logic [3:0] code);
		bfm_pkg::out_t ev;
		// resolve reports the original raise time, with info severity
		if (model_mask[code - 4'd1]) begin
			model_mask[code - 4'd1] = 1'b0;
			ev.dtc = code;
			ev.event_kind = bfm_pkg::KIND_RESOLVED;
			ev.severity = bfm_pkg::SEV_INFO;
			ev.event_time = model_raise_ms[code];
			ev.last = 1'b0;
			dtc_event_q.insert(dtc_event_q.size(), ev);
		end
	endtask

	// works out the events that one accepted beat causes, in the fixed check order
	task automatic predict_dtc_events(input bfm_pkg::in_t b);
		int            temp, volt, soc, n0;
		int            t_crit, t_warn, t_low, t_min, t_max, v_min, v_max, soc_lo;
		logic          bad;
		bfm_pkg::out_t tail;
		temp = $signed(b.temperature_dc);
		volt = b.voltage_dv;
		soc = $signed(b.soc_permille);
		t_crit = $signed(limits.temp_critical);
		t_warn = $signed(limits.temp_warning);
		t_low = $signed(limits.temp_low);
		t_min = $signed(limits.temp_valid_min);
		t_max = $signed(limits.temp_valid_max);
		v_min = limits.volt_valid_min;
		v_max = limits.volt_valid_max;
		soc_lo = limits.soc_low;
		n0 = dtc_event_q.size();
		case (b.op)
			bfm_pkg::OP_INJECT: model_inject_left = b.inject_ticks;
			bfm_pkg::OP_CLEAR: model_mask = '0;
			bfm_pkg::OP_TICK: begin
				// injection counts down; raise and resolve may share one tick
				if (model_inject_left != 0) begin
					model_inject_left = model_inject_left - 16'd1;
					post_raise(bfm_pkg::DTC_INJECTED, bfm_pkg::SEV_CRIT, b.stamp_ms);
					if (model_inject_left == 0)
						post_resolve(bfm_pkg::DTC_INJECTED);
				end
				if (b.shutdown)
					post_raise(bfm_pkg::DTC_SHUTDOWN, bfm_pkg::SEV_CRIT, b.stamp_ms);
				else
					post_resolve(bfm_pkg::DTC_SHUTDOWN);
				if (temp > t_crit)
					post_raise(bfm_pkg::DTC_OVERTEMP_CRIT, bfm_pkg::SEV_CRIT, b.stamp_ms);
				else
					post_resolve(bfm_pkg::DTC_OVERTEMP_CRIT);
				if (temp > t_warn && temp <= t_crit)
					post_raise(bfm_pkg::DTC_OVERTEMP_WARN, bfm_pkg::SEV_WARN, b.stamp_ms);
				else
					post_resolve(bfm_pkg::DTC_OVERTEMP_WARN);
				if (temp < t_low)
					post_raise(bfm_pkg::DTC_UNDERTEMP, bfm_pkg::SEV_WARN, b.stamp_ms);
				else
					post_resolve(bfm_pkg::DTC_UNDERTEMP);
				bad = temp < t_min || temp > t_max || volt < v_min || volt > v_max ||
					soc < 0 || soc > bfm_pkg::SOC_MAX_PM || model_inject_left != 0;
				if (bad)
					post_raise(bfm_pkg::DTC_SENSOR_RANGE, bfm_pkg::SEV_CRIT, b.stamp_ms);
				else
					post_resolve(bfm_pkg::DTC_SENSOR_RANGE);
				// low and critical charge never clear each other on a raise
				if (soc < bfm_pkg::SOC_CRIT_PM) begin
					post_raise(bfm_pkg::DTC_SOC_CRIT, bfm_pkg::SEV_CRIT, b.stamp_ms);
				end else if (soc < soc_lo) begin
					post_raise(bfm_pkg::DTC_SOC_LOW, bfm_pkg::SEV_WARN, b.stamp_ms);
				end else begin
					post_resolve(bfm_pkg::DTC_SOC_LOW);
					post_resolve(bfm_pkg::DTC_SOC_CRIT);
				end
			end
			default: ;
		endcase
		// flag the final event of this tick
		if (dtc_event_q.size() > n0) begin
			tail = dtc_event_q.pop_back();
			tail.last = 1'b1;
			dtc_event_q.insert(dtc_event_q.size(), tail);
		end
	endtask

	// ---------------------------------------------------------------- driver

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			send_gap <= 0;
		end else begin
			// beat taken at this edge: predict from what was on the wires
			if (in_valid && in_ready)
				predict_dtc_events(in_data);
			if (!in_valid || in_ready) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (sample_q.size() != 0 && !calm && rnd(0, 99) < send_pct) begin
					// start an idle burst; send_gap counts the idle cycles that follow this one
					send_gap <= rnd(0, 16);
					in_valid <= 1'b0;
				end else if (sample_q.size() != 0) begin
					in_valid <= 1'b1;
					in_data <= sample_q.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------- monitor

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_gap <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (dtc_event_q.size() == 0) begin
					$display("%0t ns: unexpected event, expected none, got code %0d kind %0d time %0d",
						$time, out_data.dtc, out_data.event_kind, out_data.event_time);
					mismatches++;
				end else begin
					want_ev = dtc_event_q.pop_front();
					check_field("dtc", out_data.dtc, want_ev.dtc);
					check_field("event_kind", out_data.event_kind, want_ev.event_kind);
					check_field("severity", out_data.severity, want_ev.severity);
					check_field("event_time", out_data.event_time, want_ev.event_time);
					check_field("last", out_data.last, want_ev.last);
				end
			end
			// receiver stalls in bursts too, which backs the event buffer up into in_ready
			if (recv_gap != 0) begin
				recv_gap <= recv_gap - 1;
				out_ready <= 1'b0;
			end else if (!calm && rnd(0, 99) < recv_pct) begin
				recv_gap <= rnd(0, 16);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------- stimulus

	task automatic queue_sample(input logic [31:0] ts, input int temp, input int volt,
			input int soc, input logic shut);
		bfm_pkg::in_t b;
		int           spare;
		spare = rnd(0, 65535);
		b.op = bfm_pkg::OP_TICK;
		b.stamp_ms = ts;
		b.temperature_dc = temp[11:0];
		b.voltage_dv = volt[13:0];
		b.soc_permille = soc[11:0];
		b.shutdown = shut;
		b.inject_ticks = spare[15:0];   // ignored on a tick, but keeps the bits moving
		sample_q.insert(sample_q.size(), b);
	endtask

	// non-tick beat; sample fields are junk the block must ignore
	task automatic queue_op(input logic [1:0] op, input int ticks);
		bfm_pkg::in_t b;
		int           temp, volt, soc;
		temp = rnd(-1000, 2000);
		volt = rnd(0, 10000);
		soc = rnd(-1000, 2000);
		b.op = op;
		b.stamp_ms = $urandom;
		b.temperature_dc = temp[11:0];
		b.voltage_dv = volt[13:0];
		b.soc_permille = soc[11:0];
		b.shutdown = 1'($urandom_range(0, 1));
		b.inject_ticks = ticks[15:0];
		sample_q.insert(sample_q.size(), b);
	endtask

	task automatic queue_random(input int count);
		int pick, temp_mark, volt_mark, soc_mark;
		logic [31:0] ts;
		repeat (count) begin
			pick = rnd(0, 99);
			if (pick < 7) begin
				// injection runs are mostly short so code 5 gets to resolve
				queue_op(bfm_pkg::OP_INJECT, (rnd(0, 7) == 0) ? rnd(0, 65535) : rnd(0, 6));
			end else if (pick < 12) begin
				queue_op(bfm_pkg::OP_CLEAR, rnd(0, 65535));
			end else if (pick < 14) begin
				queue_op(OP_SPARE, rnd(0, 65535));
			end else begin
				clock_ms = clock_ms + rnd(1, 1000);
				ts = (rnd(0, 7) == 0) ? $urandom : clock_ms;
				case (rnd(0, 4))
					0: temp_mark = $signed(limits.temp_critical);
					1: temp_mark = $signed(limits.temp_warning);
					2: temp_mark = $signed(limits.temp_low);
					3: temp_mark = $signed(limits.temp_valid_min);
					default: temp_mark = $signed(limits.temp_valid_max);
				endcase
				volt_mark = rnd(0, 1) ? limits.volt_valid_min : limits.volt_valid_max;
				case (rnd(0, 3))
					0: soc_mark = 0;
					1: soc_mark = bfm_pkg::SOC_CRIT_PM;
					2: soc_mark = limits.soc_low;
					default: soc_mark = bfm_pkg::SOC_MAX_PM;
				endcase
				queue_sample(ts, near_mark(temp_mark, -1000, 2000),
					near_mark(volt_mark, 0, 10000), near_mark(soc_mark, -1000, 2000),
					rnd(0, 3) == 0);
			end
		end
	endtask

	task automatic set_reg(input logic [2:0] idx, input int value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= value[13:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			bfm_pkg::REG_TEMP_CRITICAL:  limits.temp_critical = value[11:0];
			bfm_pkg::REG_TEMP_WARNING:   limits.temp_warning = value[11:0];
			bfm_pkg::REG_TEMP_LOW:       limits.temp_low = value[11:0];
			bfm_pkg::REG_TEMP_VALID_MIN: limits.temp_valid_min = value[11:0];
			bfm_pkg::REG_TEMP_VALID_MAX: limits.temp_valid_max = value[11:0];
			bfm_pkg::REG_VOLT_VALID_MIN: limits.volt_valid_min = value[13:0];
			bfm_pkg::REG_VOLT_VALID_MAX: limits.volt_valid_max = value[13:0];
			bfm_pkg::REG_SOC_LOW:        limits.soc_low = value[9:0];
			default: ;
		endcase
	endtask

	task automatic load_limits(input int t_crit, input int t_warn, input int t_low,
			input int t_min, input int t_max, input int v_min, input int v_max, input int soc_lo);
		set_reg(bfm_pkg::REG_TEMP_CRITICAL, t_crit);
		set_reg(bfm_pkg::REG_TEMP_WARNING, t_warn);
		set_reg(bfm_pkg::REG_TEMP_LOW, t_low);
		set_reg(bfm_pkg::REG_TEMP_VALID_MIN, t_min);
		set_reg(bfm_pkg::REG_TEMP_VALID_MAX, t_max);
		set_reg(bfm_pkg::REG_VOLT_VALID_MIN, v_min);
		set_reg(bfm_pkg::REG_VOLT_VALID_MAX, v_max);
		set_reg(bfm_pkg::REG_SOC_LOW, soc_lo);
	endtask

	// look at negedges so the driver's last pop and valid are settled, then let
	// beats that raise nothing work through the pipeline
	task automatic drain();
		while (sample_q.size() != 0 || in_valid || dtc_event_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int phase, t_low, t_warn, t_crit;
		// shadow state as the block comes out of reset
		limits.temp_critical = bfm_pkg::TEMP_CRITICAL_RST;
		limits.temp_warning = bfm_pkg::TEMP_WARNING_RST;
		limits.temp_low = bfm_pkg::TEMP_LOW_RST;
		limits.temp_valid_min = bfm_pkg::TEMP_VALID_MIN_RST;
		limits.temp_valid_max = bfm_pkg::TEMP_VALID_MAX_RST;
		limits.volt_valid_min = bfm_pkg::VOLT_VALID_MIN_RST;
		limits.volt_valid_max = bfm_pkg::VOLT_VALID_MAX_RST;
		limits.soc_low = bfm_pkg::SOC_LOW_RST;
		model_mask = '0;
		model_inject_left = '0;
		clock_ms = 32'd20000;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed beats against the reset thresholds
		send_pct = 20;
		recv_pct = 20;
		queue_sample(32'd0, 250, 3000, 500, 1'b0);                  // quiet tick
		queue_sample(32'hFFFF_FFFF, 2000, 10000, -1000, 1'b1);      // top of temperature and voltage range, lowest charge
		queue_sample(32'd1000, -1000, 0, 2000, 1'b0);               // bottom, resolves carry old time
		queue_sample(32'd2000, 750, 2000, 149, 1'b0);               // warning edge, low charge
		queue_sample(32'd3000, 751, 5000, 49, 1'b0);                // critical, low and critical charge
		queue_sample(32'd4000, 600, 5001, 50, 1'b0);                // voltage just above range
		queue_sample(32'd5000, 50, 1999, 150, 1'b0);                // both charge codes resolve
		queue_sample(32'd6000, 49, 3000, 1000, 1'b0);               // undertemp edge, charge at top
		queue_sample(32'd7000, -401, 3000, 1001, 1'b0);             // just outside valid ranges
		queue_sample(32'd8000, 1001, 3000, -1, 1'b0);
		queue_sample(32'd9000, 1000, 3000, 0, 1'b0);
		queue_op(OP_SPARE, 65535);
		queue_op(bfm_pkg::OP_INJECT, 3);                             // three-tick injection
		queue_sample(32'd10000, 250, 3000, 500, 1'b0);
		queue_sample(32'd11000, 250, 3000, 500, 1'b0);
		queue_sample(32'd12000, 250, 3000, 500, 1'b0);
		queue_op(bfm_pkg::OP_INJECT, 1);                             // raise and resolve in one tick
		queue_sample(32'd13000, 250, 3000, 500, 1'b0);
		queue_op(bfm_pkg::OP_INJECT, 65535);
		queue_sample(32'd14000, 250, 3000, 500, 1'b1);
		queue_op(bfm_pkg::OP_CLEAR, 0);                              // clear then raise again
		queue_sample(32'd15000, 250, 3000, 500, 1'b1);
		queue_op(bfm_pkg::OP_INJECT, 0);                             // stop injection, code 5 stays up
		queue_sample(32'd16000, 250, 3000, 500, 1'b0);
		queue_op(bfm_pkg::OP_CLEAR, 0);
		drain();

		// lowest and highest settings the tests use for every register
		send_pct = 0;
		recv_pct = 50;
		load_limits(-1000, -1000, -1000, -1000, -1000, 0, 0, 0);
		queue_random(30);
		drain();
		send_pct = 30;
		recv_pct = 10;
		load_limits(2000, 2000, 2000, 2000, 2000, 10000, 10000, 1000);
		queue_random(30);
		drain();

		// random settings, ordered on even phases and unrelated on odd ones
		for (phase = 0; phase < 4; phase++) begin
			send_pct = rnd(0, 40);
			recv_pct = rnd(0, 60);
			if (phase % 2 == 0) begin
				t_low = rnd(-1000, 400);
				t_warn = rnd(t_low, 1500);
				t_crit = rnd(t_warn, 2000);
				load_limits(t_crit, t_warn, t_low, rnd(-1000, 0), rnd(500, 2000),
					rnd(0, 5000), rnd(5000, 10000), rnd(0, 1000));
			end else begin
				load_limits(rnd(-1000, 2000), rnd(-1000, 2000), rnd(-1000, 2000),
					rnd(-1000, 2000), rnd(-1000, 2000), rnd(0, 10000), rnd(0, 10000),
					rnd(0, 1000));
			end
			queue_random(30);
			drain();
		end

		// back to defaults, full rate both sides
		calm = 1'b1;
		load_limits(bfm_pkg::TEMP_CRITICAL_RST, bfm_pkg::TEMP_WARNING_RST,
			bfm_pkg::TEMP_LOW_RST, bfm_pkg::TEMP_VALID_MIN_RST, bfm_pkg::TEMP_VALID_MAX_RST,
			bfm_pkg::VOLT_VALID_MIN_RST, bfm_pkg::VOLT_VALID_MAX_RST, bfm_pkg::SOC_LOW_RST);
		queue_random(30);
		drain();

		if (mismatches == 0 && dtc_event_q.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#(5_000_000);
		$display("Mismatches found");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/bfm_pkg.sv
sv/bfm_eval.sv
sv/bfm_emit.sv
sv/battery_fault_monitor.sv
test/tb.sv
